// ===== src/rcrh_pkg.sv =====
`default_nettype none

package rcrh_pkg;

    // Field widths
    localparam int RAW_W  = 16;
    localparam int CH_W   = 8;
    localparam int HUE_W  = 9;
    localparam int SAT_W  = 8;
    localparam int PROD_W = RAW_W + CH_W;

    // Hue and saturation divider operand widths
    localparam int HNUM_W = 17;
    localparam int SNUM_W = 2 * CH_W;

    // Pipeline layout: scaling lanes, merge stage, hue/sat dividers, output stage
    localparam int LANE_STG = CH_W + 1;
    localparam int DIV_STG  = HUE_W;
    localparam int NSTG     = LANE_STG + 1 + DIV_STG + 1;

    localparam logic [RAW_W-1:0] FS_RESET = 16'd1024;
    localparam logic [HUE_W-1:0] HUE_FULL = 9'd360;
    localparam logic [HUE_W-1:0] HUE_MAX  = 9'd359;

    typedef logic [CH_W-1:0] ch_t;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    // Channel values that ride alongside the hue and saturation dividers
    typedef struct packed {
        ch_t r;
        ch_t g;
        ch_t b;
        ch_t mx;
    } side_t;

    // Merge stage result
    typedef struct packed {
        side_t             side;
        logic [HNUM_W-1:0] hue_num;
        ch_t               hue_den;
        logic [SNUM_W-1:0] sat_num;
        ch_t               sat_den;
    } merge_t;

endpackage

`default_nettype wire

// ===== src/rcrh_if.sv =====
`default_nettype none

interface rcrh_in_if;
    import rcrh_pkg::*;
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_red;
    logic [RAW_W-1:0] raw_green;
    logic [RAW_W-1:0] raw_blue;

    modport source (output valid, output raw_red, output raw_green, output raw_blue,
                    input ready);
    modport sink (input valid, input raw_red, input raw_green, input raw_blue,
                  output ready);
endinterface

interface rcrh_out_if;
    import rcrh_pkg::*;
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  red8;
    logic [CH_W-1:0]  green8;
    logic [CH_W-1:0]  blue8;
    logic [HUE_W-1:0] hue_deg;
    logic [SAT_W-1:0] saturation;
    logic [CH_W-1:0]  brightness;

    modport source (output valid, output red8, output green8, output blue8,
                    output hue_deg, output saturation, output brightness,
                    input ready);
    modport sink (input valid, input red8, input green8, input blue8,
                  input hue_deg, input saturation, input brightness,
                  output ready);
endinterface

interface rcrh_cfg_if;
    import rcrh_pkg::*;
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] full_scale;

    modport source (output valid, output full_scale, input ready);
    modport sink (input valid, input full_scale, output ready);
endinterface

`default_nettype wire

// ===== src/rcrh_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per stage, MSB first.
// The quotient must fit in QW bits.
module rcrh_div #(
    parameter int NW = 17,
    parameter int DW = 8,
    parameter int QW = 9
) (
    input  wire logic          clk,
    input  wire logic [QW-1:0] en,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic      [QW-1:0] quo
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [NW-1:0] rem_reg [QW-1];
    logic [DW-1:0] den_reg [QW-1];
    logic [QW-1:0] quo_reg [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [CW-1:0] trial;
        logic          fit;

        if (i == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        // Trial subtract of the shifted divisor
        assign trial = CW'(den_in) << (QW - 1 - i);
        assign fit   = CW'(rem_in) >= trial;

        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                quo_reg[i] <= quo_in | (fit ? (QW'(1) << (QW - 1 - i)) : '0);
            end
        end

        if (i < QW - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en[i])
                begin
                    rem_reg[i] <= fit ? NW'(CW'(rem_in) - trial) : rem_in;
                    den_reg[i] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

`default_nettype wire

// ===== src/rcrh_lane.sv =====
`default_nettype none

// One scaling lane: floor(count * 255 / full_scale), saturated at 255.
module rcrh_lane (
    input  wire logic                          clk,
    input  wire logic [rcrh_pkg::LANE_STG-1:0] en,
    input  wire logic [rcrh_pkg::RAW_W-1:0]    fs,
    input  wire logic [rcrh_pkg::RAW_W-1:0]    count,
    output rcrh_pkg::ch_t                      scaled
);
    import rcrh_pkg::*;

    logic [RAW_W-1:0]  fs_eff;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] limit;
    logic [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0] prod_reg;
    logic [CH_W-1:0]   quo;

    // Zero full scale behaves as one
    assign fs_eff = (fs == '0) ? RAW_W'(1) : fs;

    // count * 255 as a shift and subtract
    assign prod  = {count, CH_W'(0)} - PROD_W'(count);
    assign limit = {fs_eff, CH_W'(0)};

    // Clamp an overflowing product to just under full scale * 256: quotient 255
    assign prod_next = (prod >= limit) ? limit - PROD_W'(1) : prod;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg <= prod_next;
        end
    end

    rcrh_div #(
        .NW (PROD_W),
        .DW (RAW_W),
        .QW (CH_W)
    ) u_div (
        .clk (clk),
        .en  (en[LANE_STG-1:1]),
        .num (prod_reg),
        .den (fs_eff),
        .quo (quo)
    );

    assign scaled = quo;

endmodule

`default_nettype wire

// ===== src/rcrh_merge.sv =====
`default_nettype none

// Combine the three lanes: max, min, sector and the divider operands.
module rcrh_merge (
    input  wire logic    clk,
    input  wire logic    en,
    input  wire rcrh_pkg::ch_t r,
    input  wire rcrh_pkg::ch_t g,
    input  wire rcrh_pkg::ch_t b,
    output rcrh_pkg::merge_t merged
);
    import rcrh_pkg::*;

    sector_t            sector;
    ch_t                mx;
    ch_t                mn;
    ch_t                delta;
    logic signed [9:0]  diff_s;
    logic signed [18:0] base_s;
    logic signed [18:0] delta_s;
    logic signed [18:0] num_s;
    merge_t             merge_next;
    merge_t             merge_reg;

    // Pick the max channel; ties go to red, then green
    always_comb
    begin
        if (r >= g && r >= b)
        begin
            sector = SEC_RED;
            mx     = r;
        end
        else if (g >= b)
        begin
            sector = SEC_GREEN;
            mx     = g;
        end
        else
        begin
            sector = SEC_BLUE;
            mx     = b;
        end
    end

    assign mn      = (r < g) ? ((b < r) ? b : r) : ((b < g) ? b : g);
    assign delta   = mx - mn;
    assign delta_s = $signed({11'd0, delta});

    // Sector base angle and channel difference
    always_comb
    begin
        case (sector)
            SEC_RED:
            begin
                diff_s = $signed({2'b00, g}) - $signed({2'b00, b});
                base_s = (diff_s < 0) ? 19'sd360 : 19'sd0;
            end
            SEC_GREEN:
            begin
                diff_s = $signed({2'b00, b}) - $signed({2'b00, r});
                base_s = 19'sd120;
            end
            SEC_BLUE:
            begin
                diff_s = $signed({2'b00, r}) - $signed({2'b00, g});
                base_s = 19'sd240;
            end
            default:
            begin
                diff_s = $signed({2'b00, r}) - $signed({2'b00, g});
                base_s = 19'sd240;
            end
        endcase
    end

    assign num_s = base_s * delta_s + 19'sd60 * 19'(diff_s);

    // Divider operands; grey and black force a zero hue quotient over a divisor of one
    always_comb
    begin
        merge_next.side.r  = r;
        merge_next.side.g  = g;
        merge_next.side.b  = b;
        merge_next.side.mx = mx;
        if (delta == '0 || num_s < 0)
        begin
            merge_next.hue_num = '0;
        end
        else
        begin
            merge_next.hue_num = num_s[HNUM_W-1:0];
        end
        merge_next.hue_den = (delta == '0) ? CH_W'(1) : delta;
        merge_next.sat_num = {delta, CH_W'(0)} - SNUM_W'(delta);
        merge_next.sat_den = (mx == '0) ? CH_W'(1) : mx;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            merge_reg <= merge_next;
        end
    end

    assign merged = merge_reg;

endmodule

`default_nettype wire

// ===== src/raw_colour_to_rgb_hsv.sv =====
`default_nettype none

// Raw sensor counts to 8-bit RGB and integer HSV. Each accepted triple is scaled
// by full_scale in three parallel lanes, merged into max/min/sector, and divided
// down to hue degrees and saturation. A new triple is taken every cycle while the
// output keeps accepting results, and each result passes through the bit-per-stage
// restoring dividers (9 stages in each scaling lane including the product stage,
// 9 stages for hue and saturation) plus the merge and output registers. Every
// stage stalls only when the stage after it is full, so bubbles close up while
// a result waits. The cfg channel is always ready; write full_scale only while
// no item is in flight.
module raw_colour_to_rgb_hsv (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rcrh_in_if.sink     sample,
    rcrh_out_if.source  result,
    rcrh_cfg_if.sink    cfg
);
    import rcrh_pkg::*;

    localparam int MERGE_IDX = LANE_STG;
    localparam int DIV_LO    = LANE_STG + 1;
    localparam int OUT_IDX   = NSTG - 1;

    logic [NSTG-1:0]  valid_reg;
    logic [NSTG-1:0]  valid_next;
    logic [NSTG-1:0]  ld;
    logic [RAW_W-1:0] fs_reg;
    logic [RAW_W-1:0] raw_arr [3];
    ch_t              scaled [3];
    merge_t           merged;
    side_t            side_reg [DIV_STG];
    logic [HUE_W-1:0] hue_q;
    logic [HUE_W-1:0] sat_q;
    logic [HUE_W-1:0] hue_fix;
    side_t            out_side_reg;
    logic [HUE_W-1:0] hue_reg;
    logic [SAT_W-1:0] sat_reg;

    // Hold full_scale
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg <= FS_RESET;
        end
        else if (cfg.valid)
        begin
            fs_reg <= cfg.full_scale;
        end
    end

    // A stage loads when it is empty or its content moves on
    always_comb
    begin
        ld[OUT_IDX] = !valid_reg[OUT_IDX] || result.ready;
        for (int k = OUT_IDX - 1; k >= 0; k--)
        begin
            ld[k] = !valid_reg[k] || ld[k+1];
        end
        for (int k = 0; k < NSTG; k++)
        begin
            if (!ld[k])
            begin
                valid_next[k] = valid_reg[k];
            end
            else if (k == 0)
            begin
                valid_next[k] = sample.valid;
            end
            else
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign sample.ready = ld[0];

    // Scaling lanes
    assign raw_arr[0] = sample.raw_red;
    assign raw_arr[1] = sample.raw_green;
    assign raw_arr[2] = sample.raw_blue;

    for (genvar c = 0; c < 3; c++) begin : g_lane
        rcrh_lane u_lane (
            .clk    (clk),
            .en     (ld[LANE_STG-1:0]),
            .fs     (fs_reg),
            .count  (raw_arr[c]),
            .scaled (scaled[c])
        );
    end

    rcrh_merge u_merge (
        .clk    (clk),
        .en     (ld[MERGE_IDX]),
        .r      (scaled[0]),
        .g      (scaled[1]),
        .b      (scaled[2]),
        .merged (merged)
    );

    // Hue and saturation dividers run in lockstep
    rcrh_div #(
        .NW (HNUM_W),
        .DW (CH_W),
        .QW (HUE_W)
    ) u_hue_div (
        .clk (clk),
        .en  (ld[OUT_IDX-1:DIV_LO]),
        .num (merged.hue_num),
        .den (merged.hue_den),
        .quo (hue_q)
    );

    rcrh_div #(
        .NW (SNUM_W),
        .DW (CH_W),
        .QW (HUE_W)
    ) u_sat_div (
        .clk (clk),
        .en  (ld[OUT_IDX-1:DIV_LO]),
        .num (merged.sat_num),
        .den (merged.sat_den),
        .quo (sat_q)
    );

    // Carry the channels alongside the dividers
    for (genvar s = 0; s < DIV_STG; s++) begin : g_side
        always_ff @(posedge clk)
        begin
            if (ld[DIV_LO+s])
            begin
                side_reg[s] <= (s == 0) ? merged.side : side_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    // Wrap a full turn back to zero and register the result
    assign hue_fix = (hue_q > HUE_MAX) ? hue_q - HUE_FULL : hue_q;

    always_ff @(posedge clk)
    begin
        if (ld[OUT_IDX])
        begin
            out_side_reg <= side_reg[DIV_STG-1];
            hue_reg      <= hue_fix;
            sat_reg      <= sat_q[SAT_W-1:0];
        end
    end

    assign result.valid      = valid_reg[OUT_IDX];
    assign result.red8       = out_side_reg.r;
    assign result.green8     = out_side_reg.g;
    assign result.blue8      = out_side_reg.b;
    assign result.hue_deg    = hue_reg;
    assign result.saturation = sat_reg;
    assign result.brightness = out_side_reg.mx;

`ifndef SYNTHESIS
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.hue_deg <= HUE_MAX)
        else $error("hue out of range");

    a_value_is_max: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.brightness >= result.red8 &&
                          result.brightness >= result.green8 &&
                          result.brightness >= result.blue8 &&
                          (result.brightness == result.red8 ||
                           result.brightness == result.green8 ||
                           result.brightness == result.blue8)))
        else $error("brightness is not the largest channel");

    a_grey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.red8 == result.green8 && result.green8 == result.blue8)
        |-> (result.hue_deg == '0 && result.saturation == '0))
        else $error("grey result with nonzero hue or saturation");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.saturation == '0) |-> (result.hue_deg == '0))
        else $error("hue set without saturation");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> valid_reg[0])
        else $error("accepted item lost at entry");
`endif

endmodule

`default_nettype wire
